>>> rtl/qidtt_pkg.sv
// Shared types and constants of the query id translation table.
`default_nettype none

package qidtt_pkg;

    // Command codes carried on the input tuser.
    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // Result kinds carried on the output tuser.
    localparam logic [2:0] KIND_ALLOCATED = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_MATCHED   = 3'd2;
    localparam logic [2:0] KIND_UNMATCHED = 3'd3;
    localparam logic [2:0] KIND_EXPIRED   = 3'd4;

    localparam int SLOT_FIELD_W = 6;
    localparam int IN_DATA_W    = 80;
    localparam int OUT_DATA_W   = 72;

    localparam logic [15:0] TTL_RESET = 16'd10;

    // One table entry: client data and the time it was stored.
    typedef struct packed {
        logic [15:0] stamp;
        logic [15:0] client_port;
        logic [31:0] client_ip;
        logic [15:0] client_id;
    } t_entry;

    // One result transaction.
    typedef struct packed {
        logic [2:0]              kind;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [15:0]             client_id;
        logic [31:0]             client_ip;
        logic [15:0]             client_port;
        logic                    last;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/qidtt_store.sv
// Entry memory: one write port, one registered read port.
`default_nettype none

module qidtt_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire                  i_clk,
    input  wire                  i_we,
    input  wire [ADDR_W-1:0]     i_waddr,
    input  qidtt_pkg::t_entry    i_wdata,
    input  wire                  i_re,
    input  wire [ADDR_W-1:0]     i_raddr,
    output qidtt_pkg::t_entry    o_rdata
);
    import qidtt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/qidtt_age.sv
// Age check: modular age of an entry against the time-to-live.
`default_nettype none

module qidtt_age #(
    parameter int TIME_MOD = 65536
) (
    input  wire [15:0] i_now,
    input  wire [15:0] i_stamp,
    input  wire [15:0] i_ttl,
    output logic       o_expired
);
    import qidtt_pkg::*;

    logic [16:0] diff;
    logic [16:0] age;

    always_comb begin
        diff = {1'b0, i_now} - {1'b0, i_stamp};
        // Wrap a negative difference back into the time range.
        age  = (i_now < i_stamp) ? diff + 17'(TIME_MOD) : diff;
        o_expired = age > {1'b0, i_ttl};
    end

endmodule

`default_nettype wire

>>> rtl/query_id_translation_table_core.sv
// Top level of the query id translation table: sequencer, pending bits and output stage.
`default_nettype none

// Pending-query table for a DNS relay. Each input transaction carries a command
// on s_axis_tuser: allocate stores the client id, address and port with the
// current time in a free slot, searching round-robin from the slot after the
// last one taken, and answers with the slot index (the translated id) or
// "table full"; lookup frees the slot named by server_id and returns the
// stored client data, or reports "unmatched"; tick advances the wrapping time
// counter and sweeps all slots in ascending order, emitting one "expired"
// result for every pending slot whose age exceeds ttl (possibly none). Every
// command except a silent tick marks its final result with tlast; command 3 is
// dropped. The block works on one transaction at a time and is not ready while
// it does. An allocate visits one slot per cycle. A lookup of a pending slot
// makes one memory read. A tick steps through the slots in ST_TK_READ, adds a
// registered memory read and a check in ST_TK_CHECK for each pending slot and
// ends in ST_TK_FLUSH. A waiting output transaction stalls the sequencer only
// when a new result must be presented. The ttl register may be written at any
// idle time.
module query_id_translation_table_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int TIME_MOD    = 65536
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration: ttl write.
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [15:0] i_cfg_data,
    // Command stream.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, low to high: client_id[15:0], client_ip[31:0], client_port[15:0],
    // server_id[15:0]
    input  wire  [qidtt_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: cmd[1:0]
    input  wire  [1:0]  s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata, low to high: slot[5:0], orig_client_id[15:0], orig_client_ip[31:0],
    // orig_client_port[15:0], two zero pad bits
    output logic [qidtt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: kind[2:0]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import qidtt_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);
    localparam logic [15:0] TIME_LAST = 16'(TIME_MOD - 1);
    localparam logic [15:0] DEPTH_16  = 16'(TABLE_DEPTH);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ALLOC    = 3'd1;
    localparam logic [2:0] ST_LOOKUP   = 3'd2;
    localparam logic [2:0] ST_LK_EMIT  = 3'd3;
    localparam logic [2:0] ST_TK_READ  = 3'd4;
    localparam logic [2:0] ST_TK_CHECK = 3'd5;
    localparam logic [2:0] ST_TK_FLUSH = 3'd6;

    logic [2:0]             r_state, n_state;
    logic [TABLE_DEPTH-1:0] r_pending, n_pending;
    logic [SLOT_W-1:0]      r_next_slot, n_next_slot;
    logic [15:0]            r_now, n_now;
    logic [15:0]            r_ttl;
    logic [SLOT_W-1:0]      r_idx, n_idx;
    logic [SLOT_W-1:0]      r_cnt, n_cnt;

    // Captured command payload.
    logic [15:0] r_client_id, r_client_port, r_server_id;
    logic [31:0] r_client_ip;

    // Output register and the expired result held back until we know if it is last.
    t_result r_out, n_out;
    logic    r_out_valid, n_out_valid;
    t_result r_hold, n_hold;
    logic    r_hold_valid, n_hold_valid;

    // Memory and age unit hookup.
    logic              mem_we, mem_re;
    logic [SLOT_W-1:0] mem_waddr, mem_raddr;
    t_entry            mem_wdata, mem_rdata;
    logic              expired;

    logic in_fire, out_free, sid_hit;

    qidtt_store #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    qidtt_age #(
        .TIME_MOD (TIME_MOD)
    ) u_age (
        .i_now     (r_now),
        .i_stamp   (mem_rdata.stamp),
        .i_ttl     (r_ttl),
        .o_expired (expired)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign sid_hit       = (r_server_id < DEPTH_16) && r_pending[r_server_id[SLOT_W-1:0]];

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {2'b00, r_out.client_port, r_out.client_ip,
                            r_out.client_id, r_out.slot};

    always_comb begin
        n_state      = r_state;
        n_pending    = r_pending;
        n_next_slot  = r_next_slot;
        n_now        = r_now;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !m_axis_tready;
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wdata    = '{stamp: r_now, client_port: r_client_port,
                         client_ip: r_client_ip, client_id: r_client_id};
        mem_re       = 1'b0;
        mem_raddr    = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_idx = r_next_slot;
                    n_cnt = '0;
                    case (s_axis_tuser)
                        CMD_ALLOC:  n_state = ST_ALLOC;
                        CMD_LOOKUP: n_state = ST_LOOKUP;
                        CMD_TICK: begin
                            n_now   = (r_now == TIME_LAST) ? 16'd0 : r_now + 16'd1;
                            n_idx   = '0;
                            n_state = ST_TK_READ;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ALLOC: begin
                if (!r_pending[r_idx]) begin
                    // Free slot: take it once the output stage can show the result.
                    if (out_free) begin
                        mem_we             = 1'b1;
                        n_pending[r_idx]   = 1'b1;
                        n_next_slot        = (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;
                        n_out              = '0;
                        n_out.kind         = KIND_ALLOCATED;
                        n_out.slot         = SLOT_FIELD_W'(r_idx);
                        n_out.last         = 1'b1;
                        n_out_valid        = 1'b1;
                        n_state            = ST_IDLE;
                    end
                end else if (r_cnt == LAST_SLOT) begin
                    if (out_free) begin
                        n_out       = '0;
                        n_out.kind  = KIND_FULL;
                        n_out.last  = 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    n_idx = (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_LOOKUP: begin
                if (sid_hit) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_server_id[SLOT_W-1:0];
                    n_state   = ST_LK_EMIT;
                end else if (out_free) begin
                    n_out       = '0;
                    n_out.kind  = KIND_UNMATCHED;
                    n_out.slot  = r_server_id[SLOT_FIELD_W-1:0];
                    n_out.last  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_LK_EMIT: begin
                if (out_free) begin
                    n_pending[r_server_id[SLOT_W-1:0]] = 1'b0;
                    n_out.kind        = KIND_MATCHED;
                    n_out.slot        = r_server_id[SLOT_FIELD_W-1:0];
                    n_out.client_id   = mem_rdata.client_id;
                    n_out.client_ip   = mem_rdata.client_ip;
                    n_out.client_port = mem_rdata.client_port;
                    n_out.last        = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_TK_READ: begin
                // Read only pending slots; skip free ones without a read.
                if (r_pending[r_idx]) begin
                    mem_re  = 1'b1;
                    n_state = ST_TK_CHECK;
                end else if (r_idx == LAST_SLOT) begin
                    n_state = ST_TK_FLUSH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_TK_CHECK: begin
                if (!expired || !r_hold_valid || out_free) begin
                    if (expired) begin
                        // Push the previously held expiry out, hold this one.
                        if (r_hold_valid) begin
                            n_out       = r_hold;
                            n_out_valid = 1'b1;
                        end
                        n_pending[r_idx]   = 1'b0;
                        n_hold.kind        = KIND_EXPIRED;
                        n_hold.slot        = SLOT_FIELD_W'(r_idx);
                        n_hold.client_id   = mem_rdata.client_id;
                        n_hold.client_ip   = mem_rdata.client_ip;
                        n_hold.client_port = mem_rdata.client_port;
                        n_hold.last        = 1'b0;
                        n_hold_valid       = 1'b1;
                    end
                    if (r_idx == LAST_SLOT) begin
                        n_state = ST_TK_FLUSH;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_TK_READ;
                    end
                end
            end
            ST_TK_FLUSH: begin
                if (!r_hold_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out          = r_hold;
                    n_out.last     = 1'b1;
                    n_out_valid    = 1'b1;
                    n_hold_valid   = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pending    <= '0;
            r_next_slot  <= '0;
            r_now        <= '0;
            r_ttl        <= TTL_RESET;
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pending    <= n_pending;
            r_next_slot  <= n_next_slot;
            r_now        <= n_now;
            r_out_valid  <= n_out_valid;
            r_hold_valid <= n_hold_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_ttl <= i_cfg_data;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_out  <= n_out;
        r_hold <= n_hold;
        if (in_fire) begin
            r_client_id   <= s_axis_tdata[15:0];
            r_client_ip   <= s_axis_tdata[47:16];
            r_client_port <= s_axis_tdata[63:48];
            r_server_id   <= s_axis_tdata[79:64];
        end
    end

    a_now_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_now <= TIME_LAST)
        else $error("time counter out of range");

    a_next_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_slot <= LAST_SLOT)
        else $error("next slot out of range");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_FULL) |-> (m_axis_tdata == '0 && m_axis_tlast))
        else $error("table-full result carries data");

    a_hold_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> (r_state == ST_TK_READ || r_state == ST_TK_CHECK ||
                          r_state == ST_TK_FLUSH))
        else $error("held expiry outside a sweep");

    a_alloc_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALLOC && !r_pending[r_idx] && out_free) |=> r_pending[$past(r_idx)])
        else $error("allocated slot not marked pending");

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the query id translation table core.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qidtt_pkg::*;

    localparam int DEPTH = 64;
    // Longest legal stretch without any transaction is the receiver hold-off
    // plus a settle pause; allow several times that.
    localparam int STALL_LIMIT = 5000;
    // A tick sweep with no result may still run after the last result.
    localparam int SETTLE_CYCLES = 2 * DEPTH + 20;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [15:0]           i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    query_id_translation_table_core #(
        .TABLE_DEPTH (DEPTH),
        .TIME_MOD    (65536)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow copy of the table, the time counter and the ttl register.
    logic        slot_busy   [DEPTH];
    logic [15:0] slot_cid    [DEPTH];
    logic [31:0] slot_cip    [DEPTH];
    logic [15:0] slot_cport  [DEPTH];
    logic [15:0] slot_stamp  [DEPTH];
    int          alloc_ptr;
    logic [15:0] tick_count;
    logic [15:0] ttl_value;

    t_result pending_results[$];

    bit idle_en = 1'b1;
    int rx_hold = 0;
    int rx_gap = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int commands_sent = 0;
    int results_seen = 0;
    int kind_seen [5] = '{default: 0};

    // Apply one accepted command to the shadow table and queue its results.
    function automatic void translate_command(input logic [1:0] cmd,
                                              input logic [IN_DATA_W-1:0] data);
        t_result     res;
        logic [15:0] sid;
        logic [15:0] age;
        int          s;
        int          hits;
        bit          found;
        res = '0;
        sid = data[79:64];
        hits = 0;
        found = 1'b0;
        case (cmd)
            CMD_ALLOC: begin
                for (int i = 0; i < DEPTH; i++) begin
                    s = (alloc_ptr + i) % DEPTH;
                    if (!found && !slot_busy[s]) begin
                        found = 1'b1;
                        slot_busy[s]  = 1'b1;
                        slot_cid[s]   = data[15:0];
                        slot_cip[s]   = data[47:16];
                        slot_cport[s] = data[63:48];
                        slot_stamp[s] = tick_count;
                        alloc_ptr     = (s + 1) % DEPTH;
                        res.kind      = KIND_ALLOCATED;
                        res.slot      = s[5:0];
                    end
                end
                if (!found) begin
                    res.kind = KIND_FULL;
                end
                res.last = 1'b1;
                pending_results.push_back(res);
            end
            CMD_LOOKUP: begin
                if (sid < DEPTH && slot_busy[sid]) begin
                    slot_busy[sid]  = 1'b0;
                    res.kind        = KIND_MATCHED;
                    res.client_id   = slot_cid[sid];
                    res.client_ip   = slot_cip[sid];
                    res.client_port = slot_cport[sid];
                end else begin
                    res.kind = KIND_UNMATCHED;
                end
                res.slot = sid[5:0];
                res.last = 1'b1;
                pending_results.push_back(res);
            end
            CMD_TICK: begin
                tick_count = tick_count + 16'd1;
                for (int i = 0; i < DEPTH; i++) begin
                    age = tick_count - slot_stamp[i];
                    if (slot_busy[i] && age > ttl_value) begin
                        slot_busy[i]    = 1'b0;
                        res             = '0;
                        res.kind        = KIND_EXPIRED;
                        res.slot        = i[5:0];
                        res.client_id   = slot_cid[i];
                        res.client_ip   = slot_cip[i];
                        res.client_port = slot_cport[i];
                        pending_results.push_back(res);
                        hits++;
                    end
                end
                if (hits > 0) begin
                    pending_results[pending_results.size() - 1].last = 1'b1;
                end
            end
            default: begin
                // unused command: dropped, nothing changes
            end
        endcase
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_payload();
        logic [95:0] r;
        r = {$urandom(), $urandom(), $urandom()};
        return r[IN_DATA_W-1:0];
    endfunction

    function automatic logic [IN_DATA_W-1:0] lookup_payload(input logic [15:0] sid);
        logic [IN_DATA_W-1:0] p;
        p = random_payload();
        p[79:64] = sid;
        return p;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Send one command transaction; entered and left at a falling edge.
    task automatic send_cmd(input logic [1:0] cmd, input logic [IN_DATA_W-1:0] data);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        translate_command(cmd, data);
        if (cmd != CMD_UNUSED) begin
            commands_sent++;
        end
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every queued result, then let any silent sweep end.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_ttl(input logic [15:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        ttl_value = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Reset ttl, boundary ids, a dropped command and the exact expiry edge.
    task automatic test_directed_cases();
        send_cmd(CMD_ALLOC, '0);
        send_cmd(CMD_ALLOC, '1);
        send_cmd(CMD_LOOKUP, lookup_payload(16'd1));
        send_cmd(CMD_LOOKUP, lookup_payload(16'd1));
        send_cmd(CMD_LOOKUP, lookup_payload(16'd64));
        send_cmd(CMD_LOOKUP, lookup_payload(16'hFFFF));
        send_cmd(CMD_UNUSED, '1);
        // slot 0 survives age 10 and expires at age 11
        repeat (11) send_cmd(CMD_TICK, random_payload());
        // round robin moves on instead of reusing slot 0
        send_cmd(CMD_ALLOC, random_payload());
        send_cmd(CMD_LOOKUP, lookup_payload(16'd2));
    endtask

    task automatic test_ttl_extremes();
        write_ttl(16'd0);
        send_cmd(CMD_ALLOC, random_payload());
        send_cmd(CMD_TICK, random_payload());
        write_ttl(16'd65534);
        send_cmd(CMD_ALLOC, random_payload());
        repeat (3) send_cmd(CMD_TICK, random_payload());
        send_cmd(CMD_LOOKUP, lookup_payload(16'(alloc_ptr == 0 ? DEPTH - 1 : alloc_ptr - 1)));
    endtask

    // Fill every slot, overflow, free one, refill it, then expire the whole table.
    task automatic test_table_full();
        repeat (DEPTH) send_cmd(CMD_ALLOC, random_payload());
        send_cmd(CMD_ALLOC, random_payload());
        send_cmd(CMD_LOOKUP, lookup_payload(16'd37));
        send_cmd(CMD_ALLOC, random_payload());
        send_cmd(CMD_ALLOC, random_payload());
        write_ttl(16'd0);
        send_cmd(CMD_TICK, random_payload());
        send_cmd(CMD_TICK, random_payload());
    endtask

    // Hold the receiver off while allocations keep coming, so the input stalls.
    task automatic test_backpressure();
        write_ttl(16'd20);
        @(posedge i_clk);
        rx_hold = HOLD_OFF_CYCLES;
        @(negedge i_clk);
        repeat (16) send_cmd(CMD_ALLOC, random_payload());
        repeat (4) send_cmd(CMD_LOOKUP, lookup_payload(16'($urandom_range(0, DEPTH - 1))));
    endtask

    task automatic test_random_traffic(input int count, input logic [15:0] ttl,
                                       input int alloc_pct);
        int base;
        int pick;
        int busy_list[$];
        write_ttl(ttl);
        base = commands_sent;
        while (commands_sent - base < count) begin
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct) begin
                send_cmd(CMD_ALLOC, random_payload());
            end else if (pick < alloc_pct + (100 - alloc_pct) * 6 / 10) begin
                busy_list.delete();
                for (int i = 0; i < DEPTH; i++) begin
                    if (slot_busy[i]) busy_list.push_back(i);
                end
                pick = $urandom_range(0, 9);
                if (busy_list.size() != 0 && pick < 7) begin
                    send_cmd(CMD_LOOKUP, lookup_payload(
                        16'(busy_list[$urandom_range(0, busy_list.size() - 1)])));
                end else if (pick < 9) begin
                    send_cmd(CMD_LOOKUP, lookup_payload(16'($urandom_range(0, DEPTH - 1))));
                end else begin
                    send_cmd(CMD_LOOKUP, lookup_payload(16'($urandom())));
                end
            end else if (pick < 96) begin
                send_cmd(CMD_TICK, random_payload());
            end else begin
                send_cmd(CMD_UNUSED, random_payload());
            end
        end
    endtask

    // Receiver: long hold-off on request, otherwise short random stall bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (rx_gap > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            rx_gap <= $urandom_range(0, 3);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest queued prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tuser < 3'd5) kind_seen[m_axis_tuser]++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d slot %0d", m_axis_tuser,
                       m_axis_tdata[5:0]);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("slot", 32'(want.slot), 32'(m_axis_tdata[5:0]));
                check_field("orig_client_id", 32'(want.client_id), 32'(m_axis_tdata[21:6]));
                check_field("orig_client_ip", want.client_ip, m_axis_tdata[53:22]);
                check_field("orig_client_port", 32'(want.client_port),
                            32'(m_axis_tdata[69:54]));
                check_field("last", 32'(want.last), 32'(m_axis_tlast));
            end
        end
    end

    // Watchdog: end the run if no transaction of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_ALLOC;
        m_axis_tready = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            slot_busy[i]  = 1'b0;
            slot_cid[i]   = '0;
            slot_cip[i]   = '0;
            slot_cport[i] = '0;
            slot_stamp[i] = '0;
        end
        alloc_ptr  = 0;
        tick_count = '0;
        ttl_value  = TTL_RESET;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_ttl_extremes();
        test_table_full();
        test_backpressure();
        test_random_traffic(100, 16'd3, 40);
        test_random_traffic(100, 16'd30, 45);
        test_random_traffic(70, 16'd65534, 70);
        idle_en = 1'b0;
        test_random_traffic(50, 16'd12, 45);
        drain_results();

        $display("Sent %0d commands and checked %0d results over several ttl settings,",
                 commands_sent, results_seen);
        $display("  allocated %0d, full %0d, matched %0d, unmatched %0d, expired %0d.",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
